FILE: src/arakawa_jacobian_stencil_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Arakawa Jacobian stencil.
// Each macro expands to a clocked concurrent assertion on clk with rst_n,
// or to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ARAKAWA_JACOBIAN_STENCIL_TOP_DEFINES_SVH
`define ARAKAWA_JACOBIAN_STENCIL_TOP_DEFINES_SVH
`ifndef SYNTH
`define AJS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("arakawa_jacobian_stencil: assertion failed");
`define AJS_NEVER(lbl, cond) \
    `AJS_ASSERT(lbl, !(cond))
`else
`define AJS_ASSERT(lbl, prop)
`define AJS_NEVER(lbl, cond)
`endif
`endif

FILE: src/ajs_pkg.sv
// ----------------------------------------------------------------------------
// ajs_pkg
// Types and constants shared by the Arakawa Jacobian stencil modules.
// ----------------------------------------------------------------------------
package ajs_pkg;

    localparam int DATA_W  = 32;
    localparam int IDX_W   = 7;
    localparam int IDX_N   = 128;
    localparam int S_TDATA_W = 80;
    localparam int CFG_IDX_W = 2;

    localparam int OP_W    = DATA_W + 1;
    localparam int PROD_W  = 2 * OP_W;
    localparam int ACC_W   = 70;
    localparam int LO_W    = 35;
    localparam int HI_W    = ACC_W - LO_W;
    localparam int PL_W    = LO_W + DATA_W;
    localparam int PH_W    = HI_W + DATA_W + 1;
    localparam int FULL_W  = ACC_W + DATA_W;
    localparam int FIT_LSB = 2 * DATA_W - 1;

    localparam logic [CFG_IDX_W-1:0] REG_LAST_ROW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_COL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 2'd2;

    localparam logic [IDX_W-1:0]  LAST_RESET  = 7'd127;
    localparam logic [DATA_W-1:0] SCALE_RESET = 32'd65536;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    // Neighbour codes, in the order the grids are read.
    localparam int NB_W = 3;
    localparam int NB_N = 8;
    localparam logic [NB_W-1:0] NB_P0 = 3'd0;
    localparam logic [NB_W-1:0] NB_M0 = 3'd1;
    localparam logic [NB_W-1:0] NB_0P = 3'd2;
    localparam logic [NB_W-1:0] NB_0M = 3'd3;
    localparam logic [NB_W-1:0] NB_PP = 3'd4;
    localparam logic [NB_W-1:0] NB_MM = 3'd5;
    localparam logic [NB_W-1:0] NB_MP = 3'd6;
    localparam logic [NB_W-1:0] NB_PM = 3'd7;

    // Product terms of the bracket.
    localparam int TERM_W = 4;
    localparam logic [TERM_W-1:0] T_PP_A  = 4'd0;
    localparam logic [TERM_W-1:0] T_PP_B  = 4'd1;
    localparam logic [TERM_W-1:0] T_PX_A  = 4'd2;
    localparam logic [TERM_W-1:0] T_PX_B  = 4'd3;
    localparam logic [TERM_W-1:0] T_PX_C  = 4'd4;
    localparam logic [TERM_W-1:0] T_PX_D  = 4'd5;
    localparam logic [TERM_W-1:0] T_XP_A  = 4'd6;
    localparam logic [TERM_W-1:0] T_XP_B  = 4'd7;
    localparam logic [TERM_W-1:0] T_XP_C  = 4'd8;
    localparam logic [TERM_W-1:0] T_XP_D  = 4'd9;
    localparam logic [TERM_W-1:0] TERM_LAST = T_XP_D;
    localparam logic [TERM_W-1:0] NB_LAST   = 4'd7;

    typedef struct packed {
        logic              cap_en;
        logic [NB_W-1:0]   cap_idx;
        logic              clear;
        logic              term_en;
        logic [TERM_W-1:0] term;
        logic              last;
    } ctl_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] jacobian;
        logic              saturated;
    } res_t;

endpackage

FILE: src/ajs_datapath.sv
// ----------------------------------------------------------------------------
// ajs_datapath
// Neighbour registers, one shared multiplier for the ten bracket products,
// exact accumulation, scaling, and saturation to signed Q16.16.
// ----------------------------------------------------------------------------
module ajs_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  ajs_pkg::ctl_t                   ctl,
    input  logic [ajs_pkg::DATA_W-1:0]      u_rd,
    input  logic [ajs_pkg::DATA_W-1:0]      v_rd,
    input  logic [ajs_pkg::DATA_W-1:0]      scale,
    output ajs_pkg::res_t                   res
);

    logic [ajs_pkg::DATA_W-1:0] u_nb_reg [ajs_pkg::NB_N];
    logic [ajs_pkg::DATA_W-1:0] v_nb_reg [ajs_pkg::NB_N];

    logic signed [ajs_pkg::OP_W-1:0]   op_a;
    logic signed [ajs_pkg::OP_W-1:0]   op_b;
    logic                              op_neg;
    logic signed [ajs_pkg::OP_W-1:0]   a_reg;
    logic signed [ajs_pkg::OP_W-1:0]   b_reg;
    logic signed [ajs_pkg::PROD_W-1:0] prod;
    logic signed [ajs_pkg::PROD_W-1:0] p_reg;
    logic [ajs_pkg::ACC_W-1:0]         p_ext;
    logic [ajs_pkg::ACC_W-1:0]         acc_reg;
    logic [ajs_pkg::PL_W-1:0]          pl;
    logic [ajs_pkg::PL_W-1:0]          pl_reg;
    logic signed [ajs_pkg::PH_W-1:0]   ph;
    logic signed [ajs_pkg::PH_W-1:0]   ph_reg;
    logic [ajs_pkg::FULL_W-1:0]        sum_reg;
    logic [ajs_pkg::FULL_W-1:0]        sum_next;
    logic [ajs_pkg::FULL_W-ajs_pkg::FIT_LSB-1:0] top_bits;
    logic [ajs_pkg::DATA_W-1:0]        jac_reg;
    logic                              sat_reg;

    logic v1_reg, last1_reg, neg1_reg;
    logic v2_reg, last2_reg, neg2_reg;
    logic fin3_reg, fin4_reg, fin5_reg, res_valid_reg;

    function automatic logic signed [ajs_pkg::OP_W-1:0] ext
    (
        input logic [ajs_pkg::DATA_W-1:0] x
    );
        return $signed({x[ajs_pkg::DATA_W-1], x});
    endfunction

    function automatic logic signed [ajs_pkg::OP_W-1:0] dif
    (
        input logic [ajs_pkg::DATA_W-1:0] x,
        input logic [ajs_pkg::DATA_W-1:0] y
    );
        return ext(x) - ext(y);
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctl.cap_en)
        begin
            u_nb_reg[ctl.cap_idx] <= u_rd;
            v_nb_reg[ctl.cap_idx] <= v_rd;
        end
    end

    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
        case (ctl.term)
            ajs_pkg::T_PP_A:
            begin
                op_a = dif(u_nb_reg[ajs_pkg::NB_P0], u_nb_reg[ajs_pkg::NB_M0]);
                op_b = dif(v_nb_reg[ajs_pkg::NB_0P], v_nb_reg[ajs_pkg::NB_0M]);
            end
            ajs_pkg::T_PP_B:
            begin
                op_a   = dif(u_nb_reg[ajs_pkg::NB_0P], u_nb_reg[ajs_pkg::NB_0M]);
                op_b   = dif(v_nb_reg[ajs_pkg::NB_P0], v_nb_reg[ajs_pkg::NB_M0]);
                op_neg = 1'b1;
            end
            ajs_pkg::T_PX_A:
            begin
                op_a = ext(u_nb_reg[ajs_pkg::NB_P0]);
                op_b = dif(v_nb_reg[ajs_pkg::NB_PP], v_nb_reg[ajs_pkg::NB_PM]);
            end
            ajs_pkg::T_PX_B:
            begin
                op_a   = ext(u_nb_reg[ajs_pkg::NB_M0]);
                op_b   = dif(v_nb_reg[ajs_pkg::NB_MP], v_nb_reg[ajs_pkg::NB_MM]);
                op_neg = 1'b1;
            end
            ajs_pkg::T_PX_C:
            begin
                op_a   = ext(u_nb_reg[ajs_pkg::NB_0P]);
                op_b   = dif(v_nb_reg[ajs_pkg::NB_PP], v_nb_reg[ajs_pkg::NB_MP]);
                op_neg = 1'b1;
            end
            ajs_pkg::T_PX_D:
            begin
                op_a = ext(u_nb_reg[ajs_pkg::NB_0M]);
                op_b = dif(v_nb_reg[ajs_pkg::NB_PM], v_nb_reg[ajs_pkg::NB_MM]);
            end
            ajs_pkg::T_XP_A:
            begin
                op_a = ext(u_nb_reg[ajs_pkg::NB_PP]);
                op_b = dif(v_nb_reg[ajs_pkg::NB_0P], v_nb_reg[ajs_pkg::NB_P0]);
            end
            ajs_pkg::T_XP_B:
            begin
                op_a   = ext(u_nb_reg[ajs_pkg::NB_MM]);
                op_b   = dif(v_nb_reg[ajs_pkg::NB_M0], v_nb_reg[ajs_pkg::NB_0M]);
                op_neg = 1'b1;
            end
            ajs_pkg::T_XP_C:
            begin
                op_a   = ext(u_nb_reg[ajs_pkg::NB_MP]);
                op_b   = dif(v_nb_reg[ajs_pkg::NB_0P], v_nb_reg[ajs_pkg::NB_M0]);
                op_neg = 1'b1;
            end
            ajs_pkg::T_XP_D:
            begin
                op_a = ext(u_nb_reg[ajs_pkg::NB_PM]);
                op_b = dif(v_nb_reg[ajs_pkg::NB_P0], v_nb_reg[ajs_pkg::NB_0M]);
            end
            default:
            begin
                op_a   = '0;
                op_b   = '0;
                op_neg = 1'b0;
            end
        endcase
    end

    assign prod  = a_reg * b_reg;
    assign p_ext = {{(ajs_pkg::ACC_W-ajs_pkg::PROD_W){p_reg[ajs_pkg::PROD_W-1]}}, p_reg};
    assign pl    = acc_reg[ajs_pkg::LO_W-1:0] * scale;
    assign ph    = $signed(acc_reg[ajs_pkg::ACC_W-1:ajs_pkg::LO_W]) * $signed({1'b0, scale});

    // The scaled value is the high part shifted up plus the low part.
    assign sum_next = {ph_reg[ajs_pkg::FULL_W-ajs_pkg::LO_W-1:0], {ajs_pkg::LO_W{1'b0}}}
                    + {{(ajs_pkg::FULL_W-ajs_pkg::PL_W){1'b0}}, pl_reg};

    assign top_bits = sum_reg[ajs_pkg::FULL_W-1:ajs_pkg::FIT_LSB];

    always_ff @(posedge clk)
    begin
        if (ctl.term_en)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        if (v1_reg)
        begin
            p_reg <= prod;
        end
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= neg2_reg ? acc_reg - p_ext : acc_reg + p_ext;
        end
        if (fin3_reg)
        begin
            pl_reg <= pl;
            ph_reg <= ph;
        end
        if (fin4_reg)
        begin
            sum_reg <= sum_next;
        end
        if (fin5_reg)
        begin
            // The floored result fits 32 bits exactly when the value fits 64 bits.
            if ((&top_bits) || !(|top_bits))
            begin
                jac_reg <= sum_reg[ajs_pkg::FIT_LSB:ajs_pkg::DATA_W];
                sat_reg <= 1'b0;
            end
            else
            begin
                jac_reg <= sum_reg[ajs_pkg::FULL_W-1] ? ajs_pkg::SAT_MIN : ajs_pkg::SAT_MAX;
                sat_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            last1_reg     <= 1'b0;
            neg1_reg      <= 1'b0;
            v2_reg        <= 1'b0;
            last2_reg     <= 1'b0;
            neg2_reg      <= 1'b0;
            fin3_reg      <= 1'b0;
            fin4_reg      <= 1'b0;
            fin5_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= ctl.term_en;
            last1_reg <= ctl.term_en && ctl.last;
            neg1_reg  <= op_neg;
            v2_reg    <= v1_reg;
            last2_reg <= last1_reg;
            neg2_reg  <= neg1_reg;
            fin3_reg  <= v2_reg && last2_reg;
            fin4_reg  <= fin3_reg;
            fin5_reg  <= fin4_reg;
            if (ctl.clear)
            begin
                res_valid_reg <= 1'b0;
            end
            else if (fin5_reg)
            begin
                res_valid_reg <= 1'b1;
            end
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.jacobian  = jac_reg;
    assign res.saturated = sat_reg;

endmodule

FILE: src/arakawa_jacobian_stencil_top.sv
// ----------------------------------------------------------------------------
// arakawa_jacobian_stencil_top
// Second-order Arakawa Jacobian on two periodic grids u and v held in
// single-ported memories of MAX_ROWS x MAX_COLS signed Q16.16 words.
// The input channel takes one word per item; tuser selects load or compute.
// A load word writes one u and one v sample in the cycle it is accepted
// and gives no result, so loads run at one word per cycle while no compute runs.
// A compute word reads the eight neighbours in turn, runs the ten
// bracket products through one shared multiplier, scales by the scale
// register and saturates; no further word is taken until the result
// has been loaded into the output register.
// The result waits in an output register; while the receiver stalls it
// holds, further loads are still taken, and a finished compute waits.
// Reset clears the control state and sets last_row and last_col to 127
// and scale to 1.0; the grids hold no defined value until loaded.
// Configuration is written through cfg_we, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
`include "arakawa_jacobian_stencil_top_defines.svh"

module arakawa_jacobian_stencil_top
#(
    parameter int MAX_ROWS = 128,
    parameter int MAX_COLS = 128
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // row[6:0], col[13:7], u_sample[45:14], v_sample[77:46], zero fill.
    input  logic [ajs_pkg::S_TDATA_W-1:0]        s_tdata,
    // mode[0].
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // jacobian[31:0].
    output logic [ajs_pkg::DATA_W-1:0]           m_tdata,
    // saturated[0].
    output logic                                 m_tuser,
    input  logic                                 cfg_we,
    input  logic [ajs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ajs_pkg::DATA_W-1:0]           cfg_data
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_TERMS = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic [ajs_pkg::TERM_W-1:0]  cnt_reg, cnt_next;
    logic [RW-1:0]               i_reg;
    logic [CW-1:0]               j_reg;
    logic                        cap_pending_reg;
    logic [ajs_pkg::NB_W-1:0]    cap_idx_reg;
    logic [ajs_pkg::IDX_W-1:0]   last_row_reg;
    logic [ajs_pkg::IDX_W-1:0]   last_col_reg;
    logic [ajs_pkg::DATA_W-1:0]  scale_reg;
    logic                        m_tvalid_reg;
    logic [ajs_pkg::DATA_W-1:0]  m_jac_reg;
    logic                        m_sat_reg;

    logic [ajs_pkg::DATA_W-1:0]  u_mem [DEPTH];
    logic [ajs_pkg::DATA_W-1:0]  v_mem [DEPTH];
    logic [ajs_pkg::DATA_W-1:0]  u_rd_reg;
    logic [ajs_pkg::DATA_W-1:0]  v_rd_reg;

    logic [RW-1:0] row_mod_tbl [ajs_pkg::IDX_N];
    logic [CW-1:0] col_mod_tbl [ajs_pkg::IDX_N];

    logic                        accept;
    logic                        mem_we;
    logic [AW-1:0]               mem_addr;
    logic [ajs_pkg::IDX_W-1:0]   s_row;
    logic [ajs_pkg::IDX_W-1:0]   s_col;
    logic [RW-1:0]               lr, im, ip, rd_r;
    logic [CW-1:0]               lc, jm, jp, rd_c;
    logic                        out_free;
    logic                        out_load;
    ajs_pkg::ctl_t               ctl;
    ajs_pkg::res_t               res;

    for (genvar g = 0; g < ajs_pkg::IDX_N; g++)
    begin : g_mod
        localparam int RM = g % MAX_ROWS;
        localparam int CM = g % MAX_COLS;
        assign row_mod_tbl[g] = RW'(RM);
        assign col_mod_tbl[g] = CW'(CM);
    end

    function automatic logic [AW-1:0] grid_addr
    (
        input logic [RW-1:0] r,
        input logic [CW-1:0] c
    );
        return AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    assign s_row    = s_tdata[6:0];
    assign s_col    = s_tdata[13:7];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign mem_we   = accept && !s_tuser;

    assign lr = (int'(last_row_reg) > MAX_ROWS - 1) ? RW'(MAX_ROWS - 1) : RW'(last_row_reg);
    assign lc = (int'(last_col_reg) > MAX_COLS - 1) ? CW'(MAX_COLS - 1) : CW'(last_col_reg);
    assign im = (i_reg == '0) ? lr : i_reg - RW'(1);
    assign ip = (i_reg >= lr) ? '0 : i_reg + RW'(1);
    assign jm = (j_reg == '0) ? lc : j_reg - CW'(1);
    assign jp = (j_reg >= lc) ? '0 : j_reg + CW'(1);

    always_comb
    begin
        rd_r = i_reg;
        rd_c = j_reg;
        case (cnt_reg[ajs_pkg::NB_W-1:0])
            ajs_pkg::NB_P0:
            begin
                rd_r = ip;
                rd_c = j_reg;
            end
            ajs_pkg::NB_M0:
            begin
                rd_r = im;
                rd_c = j_reg;
            end
            ajs_pkg::NB_0P:
            begin
                rd_r = i_reg;
                rd_c = jp;
            end
            ajs_pkg::NB_0M:
            begin
                rd_r = i_reg;
                rd_c = jm;
            end
            ajs_pkg::NB_PP:
            begin
                rd_r = ip;
                rd_c = jp;
            end
            ajs_pkg::NB_MM:
            begin
                rd_r = im;
                rd_c = jm;
            end
            ajs_pkg::NB_MP:
            begin
                rd_r = im;
                rd_c = jp;
            end
            ajs_pkg::NB_PM:
            begin
                rd_r = ip;
                rd_c = jm;
            end
            default:
            begin
                rd_r = i_reg;
                rd_c = j_reg;
            end
        endcase
    end

    assign mem_addr = (state_reg == ST_IDLE)
                    ? grid_addr(row_mod_tbl[s_row], col_mod_tbl[s_col])
                    : grid_addr(rd_r, rd_c);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            u_mem[mem_addr] <= s_tdata[45:14];
            v_mem[mem_addr] <= s_tdata[77:46];
        end
        u_rd_reg <= u_mem[mem_addr];
        v_rd_reg <= v_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            i_reg <= row_mod_tbl[s_row];
            j_reg <= col_mod_tbl[s_col];
        end
        if (out_load)
        begin
            m_jac_reg <= res.jacobian;
            m_sat_reg <= res.saturated;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_WAIT) && res.valid && out_free;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept && s_tuser)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cnt_next = cnt_reg + ajs_pkg::TERM_W'(1);
                if (cnt_reg == ajs_pkg::NB_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cnt_next   = '0;
                state_next = ST_TERMS;
            end
            ST_TERMS:
            begin
                cnt_next = cnt_reg + ajs_pkg::TERM_W'(1);
                if (cnt_reg == ajs_pkg::TERM_LAST)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            cap_pending_reg <= 1'b0;
            cap_idx_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
            last_row_reg    <= ajs_pkg::LAST_RESET;
            last_col_reg    <= ajs_pkg::LAST_RESET;
            scale_reg       <= ajs_pkg::SCALE_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            cap_pending_reg <= (state_reg == ST_READ);
            cap_idx_reg     <= cnt_reg[ajs_pkg::NB_W-1:0];
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    ajs_pkg::REG_LAST_ROW: last_row_reg <= cfg_data[ajs_pkg::IDX_W-1:0];
                    ajs_pkg::REG_LAST_COL: last_col_reg <= cfg_data[ajs_pkg::IDX_W-1:0];
                    ajs_pkg::REG_SCALE:    scale_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        ctl.cap_en  = cap_pending_reg;
        ctl.cap_idx = cap_idx_reg;
        ctl.clear   = accept && s_tuser;
        ctl.term_en = (state_reg == ST_TERMS);
        ctl.term    = cnt_reg;
        ctl.last    = (cnt_reg == ajs_pkg::TERM_LAST);
    end

    ajs_datapath u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .u_rd  (u_rd_reg),
        .v_rd  (v_rd_reg),
        .scale (scale_reg),
        .res   (res)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_jac_reg;
    assign m_tuser  = m_sat_reg;

    `AJS_NEVER(a_wr_busy, mem_we && state_reg != ST_IDLE)
    `AJS_ASSERT(a_cap_after_read, cap_pending_reg |-> $past(state_reg == ST_READ))
    `AJS_ASSERT(a_out_src, $rose(m_tvalid) |-> $past(state_reg == ST_WAIT && res.valid))
    `AJS_NEVER(a_res_early, res.valid && state_reg == ST_TERMS)
    `AJS_NEVER(a_cnt_rng, state_reg == ST_TERMS && cnt_reg > ajs_pkg::TERM_LAST)

endmodule
